@@ hw/rtl/ctsp_pkg.sv @@
package ctsp_pkg;

    // Tag geometry: opening brace, six hex digits, closing brace
    localparam int TAG_LEN   = 8;
    localparam int WIN_DEPTH = TAG_LEN - 1;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] OPEN_BRACE  = 8'h7B;
    localparam logic [7:0] CLOSE_BRACE = 8'h7D;
    localparam logic [7:0] DIGIT_LO    = 8'h30;
    localparam logic [7:0] DIGIT_HI    = 8'h39;
    localparam logic [7:0] LOWER_LO    = 8'h61;
    localparam logic [7:0] LOWER_HI    = 8'h66;
    localparam logic [7:0] UPPER_LO    = 8'h41;
    localparam logic [7:0] UPPER_HI    = 8'h46;

    typedef logic [TAG_LEN-1:0][7:0] win_t;

    // One queue entry: bytes to emit from the start of the window,
    // and whether the string closes with this entry
    typedef struct packed {
        win_t       bytes;
        logic [3:0] len;
        logic       last;
    } entry_t;

    function automatic logic is_hex(input logic [7:0] c);
        logic r;
        r = ((c >= DIGIT_LO) && (c <= DIGIT_HI)) ||
            ((c >= LOWER_LO) && (c <= LOWER_HI)) ||
            ((c >= UPPER_LO) && (c <= UPPER_HI));
        return r;
    endfunction

    function automatic logic is_tag(input win_t w);
        logic r;
        r = (w[0] == OPEN_BRACE) && (w[TAG_LEN-1] == CLOSE_BRACE);
        for (int i = 1; i < TAG_LEN - 1; i++)
        begin
            r = r && is_hex(w[i]);
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/color_tag_stripper_core.sv @@
// A result passes through a queue entry and then the output register before it is offered.
// Throughput: one byte accepted per cycle while the queue is not full; one result delivered per cycle while popped.
// A final byte releases up to eight results, which drain from the queue one
// per cycle while popped; the front keeps accepting until the queue fills.
// Reset (rst_n low, asynchronous) empties the window, queue and output
// register; window and queue data are not cleared.
module color_tag_stripper_core #(
    parameter int QUEUE_DEPTH = ctsp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] char_in,
    input  logic       end_of_text,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] char_out,
    output logic       has_char,
    output logic       end_of_output
);

    ctsp_pkg::entry_t wr_data;
    ctsp_pkg::entry_t rd_data;
    logic             q_wr;
    logic             q_full;
    logic             q_rd;
    logic             q_empty;

    ctsp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .char_in     (char_in),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .q_wr        (q_wr),
        .q_data      (wr_data)
    );

    ctsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (wr_data),
        .q_full  (q_full),
        .rd      (q_rd),
        .rd_data (rd_data),
        .q_empty (q_empty)
    );

    ctsp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_data        (rd_data),
        .q_empty       (q_empty),
        .q_rd          (q_rd),
        .empty         (empty),
        .pop           (pop),
        .char_out      (char_out),
        .has_char      (has_char),
        .end_of_output (end_of_output)
    );

endmodule

@@ hw/rtl/ctsp_front.sv @@
module ctsp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        char_in,
    input  logic              end_of_text,
    input  logic              q_full,
    output logic              q_wr,
    output ctsp_pkg::entry_t  q_data
);

    logic [7:0] pending_reg  [ctsp_pkg::WIN_DEPTH];
    logic [7:0] pending_next [ctsp_pkg::WIN_DEPTH];
    logic [2:0] count_reg;
    logic [2:0] count_next;

    ctsp_pkg::win_t win;
    logic           accept;
    logic           win_full;
    logic           tag_hit;
    logic [3:0]     len;

    assign full   = q_full;
    assign accept = push && !q_full;

    // Window: pending bytes with the new byte appended
    always_comb
    begin
        for (int i = 0; i < ctsp_pkg::TAG_LEN; i++)
        begin
            if (i < ctsp_pkg::WIN_DEPTH && i < int'(count_reg))
            begin
                win[i] = pending_reg[i];
            end
            else if (i == int'(count_reg))
            begin
                win[i] = char_in;
            end
            else
            begin
                win[i] = 8'h00;
            end
        end
    end

    assign win_full = (count_reg == 3'(ctsp_pkg::WIN_DEPTH));
    assign tag_hit  = win_full && ctsp_pkg::is_tag(win);

    // Classify: how many bytes from the window head go out
    always_comb
    begin
        if (end_of_text)
        begin
            if (win_full)
            begin
                len = tag_hit ? 4'd0 : 4'(ctsp_pkg::TAG_LEN);
            end
            else
            begin
                len = {1'b0, count_reg} + 4'd1;
            end
        end
        else
        begin
            len = (win_full && !tag_hit) ? 4'd1 : 4'd0;
        end
    end

    assign q_data.bytes = win;
    assign q_data.len   = len;
    assign q_data.last  = end_of_text;
    assign q_wr         = accept && ((len != 4'd0) || end_of_text);

    // Window update
    always_comb
    begin
        pending_next = pending_reg;
        count_next   = count_reg;
        if (accept)
        begin
            if (end_of_text)
            begin
                count_next = '0;
            end
            else if (!win_full)
            begin
                pending_next[count_reg] = char_in;
                count_next              = count_reg + 3'd1;
            end
            else if (tag_hit)
            begin
                count_next = '0;
            end
            else
            begin
                for (int i = 0; i < ctsp_pkg::WIN_DEPTH; i++)
                begin
                    pending_next[i] = win[i+1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pending_reg <= pending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && end_of_text) |=> (count_reg == '0))
        else $error("window not cleared after final byte");
    a_tag_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && tag_hit) |=> (count_reg == '0))
        else $error("window not cleared after tag removal");
`endif

endmodule

@@ hw/rtl/ctsp_queue.sv @@
module ctsp_queue #(
    parameter int DEPTH = ctsp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  ctsp_pkg::entry_t  wr_data,
    output logic              q_full,
    input  logic              rd,
    output ctsp_pkg::entry_t  rd_data,
    output logic              q_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ctsp_pkg::entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (cnt_reg == CNT_W'(DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr && q_full))
        else $error("write into full queue");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue fill count out of range");
`endif

endmodule

@@ hw/rtl/ctsp_back.sv @@
module ctsp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ctsp_pkg::entry_t  q_data,
    input  logic              q_empty,
    output logic              q_rd,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        char_out,
    output logic              has_char,
    output logic              end_of_output
);

    logic [2:0] pos_reg;
    logic       valid_reg;
    logic [7:0] char_reg;
    logic       has_reg;
    logic       end_reg;

    logic       load;
    logic       entry_done;
    logic       has_byte;

    // Walk the head entry one byte per result
    assign has_byte   = (q_data.len != 4'd0);
    assign entry_done = !has_byte || ({1'b0, pos_reg} == (q_data.len - 4'd1));
    assign load       = !q_empty && (!valid_reg || pop);
    assign q_rd       = load && entry_done;

    assign empty         = !valid_reg;
    assign char_out      = char_reg;
    assign has_char      = has_reg;
    assign end_of_output = end_reg;

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= has_byte ? q_data.bytes[pos_reg] : 8'h00;
            has_reg  <= has_byte;
            end_reg  <= q_data.last && entry_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                pos_reg   <= entry_done ? '0 : pos_reg + 3'd1;
            end
            else if (pop)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !has_char) |-> (end_of_output && (char_out == 8'h00)))
        else $error("marker-only result malformed");
`endif

endmodule

@@ tb/sv/color_tag_stripper_core_test.sv @@
`timescale 1ns / 1ps

module color_tag_stripper_core_test;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int TEXT_GOAL    = 300;
    localparam int CALM_TAIL    = 40;
    localparam int DRAIN_CYCLES = 8;

    // One byte of the text stream, with its end-of-string flag
    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } text_byte_t;

    // One result: kept byte, carry flag, end-of-string marker
    typedef struct packed {
        logic [7:0] ch;
        logic       has;
        logic       last;
    } strip_res_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] char_in = 8'h00;
    logic       end_of_text = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] char_out;
    logic       has_char;
    logic       end_of_output;

    text_byte_t text_q [$];
    strip_res_t kept_q [$];
    logic [7:0] build_q [$];

    // Predictor state: bytes held back in the window, up to one fewer than a tag
    logic [7:0] held [0:ctsp_pkg::WIN_DEPTH-1];
    int         held_n = 0;

    text_byte_t next_byte;
    logic       byte_taken = 1'b0;
    int         push_gap = 0;
    int         pop_gap = 0;
    int         mismatches = 0;
    int         cycles = 0;

    color_tag_stripper_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .char_in       (char_in),
        .end_of_text   (end_of_text),
        .empty         (empty),
        .pop           (pop),
        .char_out      (char_out),
        .has_char      (has_char),
        .end_of_output (end_of_output)
    );

    function automatic bit hex_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
               (c >= "A" && c <= "F");
    endfunction

    function automatic logic [7:0] rand_hex();
        case ($urandom_range(0, 2))
            0: return 8'(ctsp_pkg::DIGIT_LO + $urandom_range(0, 9));
            1: return 8'(ctsp_pkg::LOWER_LO + $urandom_range(0, 5));
            default: return 8'(ctsp_pkg::UPPER_LO + $urandom_range(0, 5));
        endcase
    endfunction

    // Expected results for one accepted byte
    task automatic strip_step(input logic [7:0] ch, input logic fin);
        logic [7:0] w [0:ctsp_pkg::TAG_LEN-1];
        int n;
        int k;
        bit tag;
        n = held_n;
        k = 0;
        for (int i = 0; i < n; i++)
        begin
            w[i] = held[i];
        end
        w[n] = ch;
        n++;
        // full window: drop a whole tag, or release the oldest byte
        if (n == ctsp_pkg::TAG_LEN)
        begin
            tag = (w[0] == ctsp_pkg::OPEN_BRACE) &&
                  (w[ctsp_pkg::TAG_LEN-1] == ctsp_pkg::CLOSE_BRACE);
            for (int i = 1; i < ctsp_pkg::TAG_LEN - 1; i++)
            begin
                tag = tag && hex_char(w[i]);
            end
            if (tag)
            begin
                n = 0;
            end
            else
            begin
                kept_q.push_back('{ch: w[0], has: 1'b1, last: 1'b0});
                for (int i = 0; i < ctsp_pkg::TAG_LEN - 1; i++)
                begin
                    w[i] = w[i+1];
                end
                n = ctsp_pkg::TAG_LEN - 1;
                k = 1;
            end
        end
        // end of string: flush, or a bare marker when nothing is left
        if (fin)
        begin
            if (n == 0 && k == 0)
            begin
                kept_q.push_back('{ch: 8'h00, has: 1'b0, last: 1'b1});
            end
            else
            begin
                for (int i = 0; i < n; i++)
                begin
                    kept_q.push_back('{ch: w[i], has: 1'b1, last: (i == n - 1)});
                end
            end
            n = 0;
        end
        for (int i = 0; i < n; i++)
        begin
            held[i] = w[i];
        end
        held_n = n;
    endtask

    task automatic put_byte(input logic [7:0] ch, input logic fin);
        text_q.push_back('{ch: ch, fin: fin});
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            put_byte(s[i], i == s.len() - 1);
        end
    endtask

    // Well-formed tag with random digits; a broken one has one random byte
    task automatic append_tag(input bit broken);
        logic [7:0] t [0:ctsp_pkg::TAG_LEN-1];
        t[0] = ctsp_pkg::OPEN_BRACE;
        t[ctsp_pkg::TAG_LEN-1] = ctsp_pkg::CLOSE_BRACE;
        for (int i = 1; i < ctsp_pkg::TAG_LEN - 1; i++)
        begin
            t[i] = rand_hex();
        end
        if (broken)
        begin
            t[$urandom_range(0, ctsp_pkg::TAG_LEN - 1)] = 8'($urandom_range(1, 255));
        end
        for (int i = 0; i < ctsp_pkg::TAG_LEN; i++)
        begin
            build_q.push_back(t[i]);
        end
    endtask

    task automatic report_mismatch(input string what, input strip_res_t want,
                                   input strip_res_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t %s: expected ch=%02h has=%0b last=%0b, got ch=%02h has=%0b last=%0b",
                     $realtime, what, want.ch, want.has, want.last,
                     got.ch, got.has, got.last);
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Input side: hold until accepted, otherwise idle or present the next byte
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else if (push && !byte_taken)
        begin
            push <= 1'b1;
        end
        else if (push_gap > 0)
        begin
            push <= 1'b0;
            push_gap <= push_gap - 1;
        end
        else if (text_q.size() > 0)
        begin
            if (text_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
            begin
                push <= 1'b0;
                push_gap <= $urandom_range(0, 6);
            end
            else
            begin
                next_byte = text_q.pop_front();
                char_in <= next_byte.ch;
                end_of_text <= next_byte.fin;
                push <= 1'b1;
            end
        end
        else
        begin
            push <= 1'b0;
        end
    end

    // Output side: stall in bursts, none once the stimulus is nearly done
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (pop_gap > 0)
        begin
            pop <= 1'b0;
            pop_gap <= pop_gap - 1;
        end
        else if (text_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
        begin
            pop <= 1'b0;
            pop_gap <= $urandom_range(0, 6);
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    // Monitor: predict on accepted bytes, check each popped transaction
    always @(posedge clk)
    begin
        strip_res_t got;
        strip_res_t want;
        if (!rst_n)
        begin
            byte_taken <= 1'b0;
        end
        else
        begin
            byte_taken <= push && !full;
            if (push && !full)
            begin
                strip_step(char_in, end_of_text);
            end
            if (pop && !empty)
            begin
                got = '{ch: char_out, has: has_char, last: end_of_output};
                if (kept_q.size() == 0)
                begin
                    report_mismatch("unexpected result", '0, got);
                end
                else
                begin
                    want = kept_q.pop_front();
                    if (got.ch !== want.ch || got.has !== want.has ||
                        got.last !== want.last)
                    begin
                        report_mismatch("result mismatch", want, got);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("color_tag_stripper_core verification failed");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int len_goal;

        // directed: tag alone (bare marker), zero and 0xFF bytes in a short
        // tail, near-miss digits giving a full eight-result flush, one byte
        put_str("{09afAF}");
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte("a", 1'b1);
        put_str("{/:`gG@}");
        put_byte(ctsp_pkg::CLOSE_BRACE, 1'b1);

        // random strings, mostly built from tags and broken tags
        while (text_q.size() < TEXT_GOAL)
        begin
            len_goal = $urandom_range(1, 24);
            build_q.delete();
            while (build_q.size() < len_goal)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: append_tag(1'b0);
                    4, 5: append_tag(1'b1);
                    6: build_q.push_back($urandom_range(0, 1) ? ctsp_pkg::OPEN_BRACE
                                                              : ctsp_pkg::CLOSE_BRACE);
                    7: build_q.push_back(rand_hex());
                    default: build_q.push_back(8'($urandom_range(1, 255)));
                endcase
            end
            // sometimes cut the string so that it ends inside a tag
            if ($urandom_range(0, 3) == 0)
            begin
                while (build_q.size() > len_goal)
                begin
                    void'(build_q.pop_back());
                end
            end
            for (int i = 0; i < build_q.size(); i++)
            begin
                put_byte(build_q[i], i == build_q.size() - 1);
            end
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (text_q.size() != 0 || push)
        begin
            @(posedge clk);
        end
        while (kept_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (kept_q.size() != 0)
        begin
            mismatches++;
        end
        if (mismatches == 0)
        begin
            $display("color_tag_stripper_core verification clean");
        end
        else
        begin
            $display("color_tag_stripper_core verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/ctsp_pkg.sv
hw/rtl/ctsp_front.sv
hw/rtl/ctsp_queue.sv
hw/rtl/ctsp_back.sv
hw/rtl/color_tag_stripper_core.sv
tb/sv/color_tag_stripper_core_test.sv
